// ===== design/bpcf_pkg.sv =====
package bpcf_pkg;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temp;
    } t_in_item;

    typedef struct packed {
        logic signed [18:0] temperature;
        logic signed [31:0] pressure_comp;
        logic signed [31:0] pressure_avg;
    } t_out_item;

    typedef struct packed {
        logic [15:0] coeff_sens;
        logic [15:0] coeff_offset;
        logic [15:0] coeff_sens_tempco;
        logic [15:0] coeff_offset_tempco;
        logic [15:0] coeff_ref_temp;
        logic [15:0] coeff_temp_sens;
        logic [4:0]  filter_shift;
    } t_cfg;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_COEFF_SENS          = 3'd0;
    localparam logic [2:0] REG_COEFF_OFFSET        = 3'd1;
    localparam logic [2:0] REG_COEFF_SENS_TEMPCO   = 3'd2;
    localparam logic [2:0] REG_COEFF_OFFSET_TEMPCO = 3'd3;
    localparam logic [2:0] REG_COEFF_REF_TEMP      = 3'd4;
    localparam logic [2:0] REG_COEFF_TEMP_SENS     = 3'd5;
    localparam logic [2:0] REG_FILTER_SHIFT        = 3'd6;

    localparam logic [4:0] FILTER_SHIFT_RESET = 5'd4;
    localparam logic [4:0] FILTER_SHIFT_MIN   = 5'd1;
    localparam logic [4:0] FILTER_SHIFT_MAX   = 5'd16;

    localparam int TEMP_REF = 2000;
    localparam int TEMP_LOW = -1500;
    localparam int T1_SHIFT = 23;
    localparam int T2_SHIFT = 31;
    localparam int OFF_TC_SHIFT = 7;
    localparam int SENS_TC_SHIFT = 8;
    localparam int P_SHIFT1 = 21;
    localparam int P_SHIFT2 = 15;
    localparam int SENS_SPLIT = 20;

    localparam logic signed [31:0] P_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] P_MIN   = 32'sh8000_0000;
    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DT,
        ST_T1,
        ST_T2,
        ST_OFF,
        ST_SENS,
        ST_X,
        ST_Y11,
        ST_Y7,
        ST_PLO,
        ST_PHI,
        ST_PSUM,
        ST_PDIFF,
        ST_P10,
        ST_SUM,
        ST_FILT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DT,
        OP_T1,
        OP_T2,
        OP_OFF,
        OP_SENS,
        OP_X,
        OP_Y11,
        OP_Y7,
        OP_PLO,
        OP_PHI,
        OP_PSUM,
        OP_PDIFF,
        OP_P10,
        OP_SUM,
        OP_FILT
    } t_op;

    typedef struct packed {
        logic capture;
        t_op  op;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_status;

endpackage

// ===== design/bpcf_regs.sv =====
module bpcf_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output bpcf_pkg::t_cfg   o_cfg
);

    bpcf_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff_sens          <= '0;
            r_cfg.coeff_offset        <= '0;
            r_cfg.coeff_sens_tempco   <= '0;
            r_cfg.coeff_offset_tempco <= '0;
            r_cfg.coeff_ref_temp      <= '0;
            r_cfg.coeff_temp_sens     <= '0;
            r_cfg.filter_shift        <= bpcf_pkg::FILTER_SHIFT_RESET;
        end else if (wr_en) begin
            case (idx)
                bpcf_pkg::REG_COEFF_SENS:          r_cfg.coeff_sens <= pwdata[15:0];
                bpcf_pkg::REG_COEFF_OFFSET:        r_cfg.coeff_offset <= pwdata[15:0];
                bpcf_pkg::REG_COEFF_SENS_TEMPCO:   r_cfg.coeff_sens_tempco <= pwdata[15:0];
                bpcf_pkg::REG_COEFF_OFFSET_TEMPCO: r_cfg.coeff_offset_tempco <= pwdata[15:0];
                bpcf_pkg::REG_COEFF_REF_TEMP:      r_cfg.coeff_ref_temp <= pwdata[15:0];
                bpcf_pkg::REG_COEFF_TEMP_SENS:     r_cfg.coeff_temp_sens <= pwdata[15:0];
                bpcf_pkg::REG_FILTER_SHIFT:        r_cfg.filter_shift <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            bpcf_pkg::REG_COEFF_SENS:          prdata = {16'h0, r_cfg.coeff_sens};
            bpcf_pkg::REG_COEFF_OFFSET:        prdata = {16'h0, r_cfg.coeff_offset};
            bpcf_pkg::REG_COEFF_SENS_TEMPCO:   prdata = {16'h0, r_cfg.coeff_sens_tempco};
            bpcf_pkg::REG_COEFF_OFFSET_TEMPCO: prdata = {16'h0, r_cfg.coeff_offset_tempco};
            bpcf_pkg::REG_COEFF_REF_TEMP:      prdata = {16'h0, r_cfg.coeff_ref_temp};
            bpcf_pkg::REG_COEFF_TEMP_SENS:     prdata = {16'h0, r_cfg.coeff_temp_sens};
            bpcf_pkg::REG_FILTER_SHIFT:        prdata = {27'h0, r_cfg.filter_shift};
            default:                           prdata = 32'h0;
        endcase
    end

endmodule

// ===== design/bpcf_ctrl.sv =====
module bpcf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  bpcf_pkg::t_dp_status   i_status,
    output bpcf_pkg::t_dp_cmd      o_cmd
);

    bpcf_pkg::t_state r_state;
    bpcf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpcf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            bpcf_pkg::ST_IDLE:  n_state = i_in_valid ? bpcf_pkg::ST_DT : bpcf_pkg::ST_IDLE;
            bpcf_pkg::ST_DT:    n_state = bpcf_pkg::ST_T1;
            bpcf_pkg::ST_T1:    n_state = bpcf_pkg::ST_T2;
            bpcf_pkg::ST_T2:    n_state = bpcf_pkg::ST_OFF;
            bpcf_pkg::ST_OFF:   n_state = bpcf_pkg::ST_SENS;
            bpcf_pkg::ST_SENS:  n_state = bpcf_pkg::ST_X;
            bpcf_pkg::ST_X:     n_state = bpcf_pkg::ST_Y11;
            bpcf_pkg::ST_Y11:   n_state = bpcf_pkg::ST_Y7;
            bpcf_pkg::ST_Y7:    n_state = bpcf_pkg::ST_PLO;
            bpcf_pkg::ST_PLO:   n_state = bpcf_pkg::ST_PHI;
            bpcf_pkg::ST_PHI:   n_state = bpcf_pkg::ST_PSUM;
            bpcf_pkg::ST_PSUM:  n_state = bpcf_pkg::ST_PDIFF;
            bpcf_pkg::ST_PDIFF: n_state = bpcf_pkg::ST_P10;
            bpcf_pkg::ST_P10:   n_state = bpcf_pkg::ST_SUM;
            bpcf_pkg::ST_SUM:   n_state = bpcf_pkg::ST_FILT;
            bpcf_pkg::ST_FILT:  n_state = bpcf_pkg::ST_DONE;
            bpcf_pkg::ST_DONE: begin
                n_state = i_status.out_full ? bpcf_pkg::ST_DONE : bpcf_pkg::ST_IDLE;
            end
            default:            n_state = bpcf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != bpcf_pkg::ST_IDLE);
        o_cmd.capture = (r_state == bpcf_pkg::ST_IDLE) && i_in_valid;
        o_cmd.emit    = (r_state == bpcf_pkg::ST_DONE) && !i_status.out_full;
        case (r_state)
            bpcf_pkg::ST_DT:    o_cmd.op = bpcf_pkg::OP_DT;
            bpcf_pkg::ST_T1:    o_cmd.op = bpcf_pkg::OP_T1;
            bpcf_pkg::ST_T2:    o_cmd.op = bpcf_pkg::OP_T2;
            bpcf_pkg::ST_OFF:   o_cmd.op = bpcf_pkg::OP_OFF;
            bpcf_pkg::ST_SENS:  o_cmd.op = bpcf_pkg::OP_SENS;
            bpcf_pkg::ST_X:     o_cmd.op = bpcf_pkg::OP_X;
            bpcf_pkg::ST_Y11:   o_cmd.op = bpcf_pkg::OP_Y11;
            bpcf_pkg::ST_Y7:    o_cmd.op = bpcf_pkg::OP_Y7;
            bpcf_pkg::ST_PLO:   o_cmd.op = bpcf_pkg::OP_PLO;
            bpcf_pkg::ST_PHI:   o_cmd.op = bpcf_pkg::OP_PHI;
            bpcf_pkg::ST_PSUM:  o_cmd.op = bpcf_pkg::OP_PSUM;
            bpcf_pkg::ST_PDIFF: o_cmd.op = bpcf_pkg::OP_PDIFF;
            bpcf_pkg::ST_P10:   o_cmd.op = bpcf_pkg::OP_P10;
            bpcf_pkg::ST_SUM:   o_cmd.op = bpcf_pkg::OP_SUM;
            bpcf_pkg::ST_FILT:  o_cmd.op = bpcf_pkg::OP_FILT;
            default:            o_cmd.op = bpcf_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== design/bpcf_dp.sv =====
module bpcf_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bpcf_pkg::t_cfg         i_cfg,
    input  bpcf_pkg::t_dp_cmd      i_cmd,
    output bpcf_pkg::t_dp_status   o_status,
    input  bpcf_pkg::t_in_item     i_in_data,
    output logic                   o_out_valid,
    output bpcf_pkg::t_out_item    o_out_data,
    input  logic                   i_out_stall
);

    logic [23:0]         r_d1;
    logic [23:0]         r_d2;
    logic signed [24:0]  r_dt;
    logic signed [18:0]  r_t1;
    logic [16:0]         r_t2;
    logic signed [39:0]  r_off;
    logic signed [39:0]  r_sens;
    logic signed [63:0]  r_acc;
    logic signed [43:0]  r_pq;
    logic signed [31:0]  r_p;
    logic signed [48:0]  r_fdiff;
    logic signed [47:0]  r_fsum;
    logic signed [31:0]  r_filt;
    logic signed [51:0]  r_prod;
    logic                r_out_valid;
    bpcf_pkg::t_out_item r_out;

    logic signed [25:0]  mul_a;
    logic signed [25:0]  mul_b;
    logic signed [25:0]  dt_ext;
    logic signed [19:0]  u;
    logic signed [22:0]  u_ext;
    logic signed [22:0]  u5;
    logic signed [19:0]  v;
    logic signed [22:0]  v_ext23;
    logic signed [23:0]  v_ext24;
    logic signed [22:0]  v7;
    logic signed [23:0]  v11;
    logic                lt_ref;
    logic                lt_low;
    logic signed [43:0]  pq_sh;
    logic signed [33:0]  p10;
    logic signed [31:0]  p_sat;
    logic signed [49:0]  sum50;
    logic signed [47:0]  sum_sat;
    logic [4:0]          kc;
    logic signed [48:0]  rnd;
    logic signed [48:0]  fsum_rnd;
    logic signed [48:0]  filt_sh;
    logic signed [31:0]  filt_sat;
    logic [19:0]         temp_full;

    // second-order operands: u = T1 - 2000, v = T1 + 1500
    assign dt_ext  = {r_dt[24], r_dt};
    assign u       = {r_t1[18], r_t1} - 20'(bpcf_pkg::TEMP_REF);
    assign u_ext   = {{3{u[19]}}, u};
    assign u5      = (u_ext <<< 2) + u_ext;
    assign v       = {r_t1[18], r_t1} - 20'(bpcf_pkg::TEMP_LOW);
    assign v_ext23 = {{3{v[19]}}, v};
    assign v_ext24 = {{4{v[19]}}, v};
    assign v7      = (v_ext23 <<< 3) - v_ext23;
    assign v11     = (v_ext24 <<< 3) + (v_ext24 <<< 1) + v_ext24;
    assign lt_ref  = r_t1 < 19'(bpcf_pkg::TEMP_REF);
    assign lt_low  = r_t1 < 19'(bpcf_pkg::TEMP_LOW);

    always_comb begin
        case (i_cmd.op)
            bpcf_pkg::OP_T1: begin
                mul_a = dt_ext;
                mul_b = {10'h0, i_cfg.coeff_temp_sens};
            end
            bpcf_pkg::OP_T2: begin
                mul_a = dt_ext;
                mul_b = dt_ext;
            end
            bpcf_pkg::OP_OFF: begin
                mul_a = {10'h0, i_cfg.coeff_offset_tempco};
                mul_b = dt_ext;
            end
            bpcf_pkg::OP_SENS: begin
                mul_a = {10'h0, i_cfg.coeff_sens_tempco};
                mul_b = dt_ext;
            end
            bpcf_pkg::OP_X: begin
                mul_a = {{6{u[19]}}, u};
                mul_b = {{3{u5[22]}}, u5};
            end
            bpcf_pkg::OP_Y11: begin
                mul_a = {{6{v[19]}}, v};
                mul_b = {{2{v11[23]}}, v11};
            end
            bpcf_pkg::OP_Y7: begin
                mul_a = {{6{v[19]}}, v};
                mul_b = {{3{v7[22]}}, v7};
            end
            bpcf_pkg::OP_PLO: begin
                mul_a = {2'b00, r_d1};
                mul_b = {6'h0, r_sens[19:0]};
            end
            bpcf_pkg::OP_PHI: begin
                mul_a = {2'b00, r_d1};
                mul_b = {{6{r_sens[39]}}, r_sens[39:20]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // pressure scale and saturation
    assign pq_sh = r_pq >>> bpcf_pkg::P_SHIFT2;
    assign p10   = (34'(pq_sh) <<< 3) + (34'(pq_sh) <<< 1);

    always_comb begin
        if (p10 > 34'(bpcf_pkg::P_MAX)) begin
            p_sat = bpcf_pkg::P_MAX;
        end else if (p10 < 34'(bpcf_pkg::P_MIN)) begin
            p_sat = bpcf_pkg::P_MIN;
        end else begin
            p_sat = p10[31:0];
        end
    end

    assign sum50 = 50'(r_fdiff) + 50'(r_p);

    always_comb begin
        if (sum50 > 50'(bpcf_pkg::SUM_MAX)) begin
            sum_sat = bpcf_pkg::SUM_MAX;
        end else if (sum50 < 50'(bpcf_pkg::SUM_MIN)) begin
            sum_sat = bpcf_pkg::SUM_MIN;
        end else begin
            sum_sat = sum50[47:0];
        end
    end

    always_comb begin
        if (i_cfg.filter_shift < bpcf_pkg::FILTER_SHIFT_MIN) begin
            kc = bpcf_pkg::FILTER_SHIFT_MIN;
        end else if (i_cfg.filter_shift > bpcf_pkg::FILTER_SHIFT_MAX) begin
            kc = bpcf_pkg::FILTER_SHIFT_MAX;
        end else begin
            kc = i_cfg.filter_shift;
        end
    end

    assign rnd      = 49'sd1 <<< (kc - 5'd1);
    assign fsum_rnd = 49'(r_fsum) + rnd;
    assign filt_sh  = fsum_rnd >>> kc;

    always_comb begin
        if (filt_sh > 49'(bpcf_pkg::P_MAX)) begin
            filt_sat = bpcf_pkg::P_MAX;
        end else if (filt_sh < 49'(bpcf_pkg::P_MIN)) begin
            filt_sat = bpcf_pkg::P_MIN;
        end else begin
            filt_sat = filt_sh[31:0];
        end
    end

    assign temp_full = {r_t1[18], r_t1} - {3'b000, r_t2};

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.capture) begin
            r_d1 <= i_in_data.raw_pressure;
            r_d2 <= i_in_data.raw_temp;
        end
        case (i_cmd.op)
            bpcf_pkg::OP_DT: begin
                r_dt    <= {1'b0, r_d2} - {1'b0, i_cfg.coeff_ref_temp, 8'h00};
                r_fdiff <= 49'(r_fsum) - 49'(r_filt);
            end
            bpcf_pkg::OP_T2: begin
                r_t1 <= 19'(r_prod >>> bpcf_pkg::T1_SHIFT) + 19'(bpcf_pkg::TEMP_REF);
            end
            bpcf_pkg::OP_OFF: begin
                r_t2 <= lt_ref ? r_prod[bpcf_pkg::T2_SHIFT+16:bpcf_pkg::T2_SHIFT] : '0;
            end
            bpcf_pkg::OP_SENS: begin
                r_off <= {8'h00, i_cfg.coeff_offset, 16'h0000}
                         + 40'(r_prod >>> bpcf_pkg::OFF_TC_SHIFT);
            end
            bpcf_pkg::OP_X: begin
                r_sens <= {9'h000, i_cfg.coeff_sens, 15'h0000}
                          + 40'(r_prod >>> bpcf_pkg::SENS_TC_SHIFT);
            end
            bpcf_pkg::OP_Y11: begin
                if (lt_ref) begin
                    r_off  <= r_off - 40'(r_prod >>> 1);
                    r_sens <= r_sens - 40'(r_prod >>> 2);
                end
            end
            bpcf_pkg::OP_Y7: begin
                if (lt_low) begin
                    r_sens <= r_sens - 40'(r_prod >>> 1);
                end
            end
            bpcf_pkg::OP_PLO: begin
                if (lt_low) begin
                    r_off <= r_off - 40'(r_prod);
                end
            end
            bpcf_pkg::OP_PHI: begin
                r_acc <= 64'(r_prod);
            end
            bpcf_pkg::OP_PSUM: begin
                r_acc <= r_acc + (64'(r_prod) <<< bpcf_pkg::SENS_SPLIT);
            end
            bpcf_pkg::OP_PDIFF: begin
                r_pq <= 44'(r_acc >>> bpcf_pkg::P_SHIFT1) - 44'(r_off);
            end
            bpcf_pkg::OP_P10: begin
                r_p <= p_sat;
            end
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out.temperature   <= temp_full[18:0];
            r_out.pressure_comp <= r_p;
            r_out.pressure_avg  <= r_filt;
        end
    end

    // filter state and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsum      <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == bpcf_pkg::OP_SUM) begin
                r_fsum <= sum_sat;
            end
            if (i_cmd.op == bpcf_pkg::OP_FILT) begin
                r_filt <= filt_sat;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_full = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ===== design/baro_pressure_compensation_filter.sv =====
// Barometric pressure compensation with exponential pressure averaging.
// Input channel: i_in_valid / o_in_stall carry one transaction of raw
// pressure and raw temperature words. Output channel: o_out_valid /
// i_out_stall return one transaction per input: compensated temperature,
// pressure times ten and the averaged pressure.
// Calibration words and the average shift are written over the APB port
// (register i at byte address 4*i); the user must write them only while the
// block is idle, as the block itself does not enforce it. One item is
// processed at a time, so no new input is taken before the previous one is
// through the sequence of products in one shared 26x26 multiplier plus the
// averaging steps.
// The result sits in an output register, so a new input is taken while the
// previous result still waits. If the receiver stalls, the next finished
// result is held inside and no further input is taken until the output
// register frees up.
// Reset clears the calibration words to zero, the shift to 4 and the
// average state to zero.
module baro_pressure_compensation_filter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bpcf_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bpcf_pkg::t_out_item   o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    bpcf_pkg::t_cfg       cfg;
    bpcf_pkg::t_dp_cmd    cmd;
    bpcf_pkg::t_dp_status status;

    bpcf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bpcf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== test/baro_pressure_compensation_filter_test.sv =====
module baro_pressure_compensation_filter_test;

    localparam logic [2:0] REG_RESERVED = 3'd7;
    localparam int IDLE_PCT = 31;
    localparam int MAX_REPORTS = 40;
    localparam int DRAIN_CYCLES = 24;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    bpcf_pkg::t_in_item   in_data = '0;
    logic                 out_stall = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [4:0]           paddr = '0;
    logic [31:0]          pwdata = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    bpcf_pkg::t_out_item  o_out_data;
    logic [31:0]          prdata;
    logic                 pready;

    // shadow copy of the calibration and of the averaging state
    bpcf_pkg::t_cfg       cal;
    longint               avg_sum;
    longint               avg_value;
    bpcf_pkg::t_out_item  expected_readings[$];
    int                   mismatches = 0;
    int                   send_gap_pct = IDLE_PCT;
    int                   stall_pct = IDLE_PCT;

    baro_pressure_compensation_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // compensation and averaging for one transaction; advances the average state
    function automatic bpcf_pkg::t_out_item predict_reading(input bpcf_pkg::t_in_item item);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, t1, t2, off2, sens2, temp, off, sens, p, sum, filt, x, y;
        int k;
        bpcf_pkg::t_out_item r;
        d1 = longint'(item.raw_pressure);
        d2 = longint'(item.raw_temp);
        c1 = longint'(cal.coeff_sens);
        c2 = longint'(cal.coeff_offset);
        c3 = longint'(cal.coeff_sens_tempco);
        c4 = longint'(cal.coeff_offset_tempco);
        c5 = longint'(cal.coeff_ref_temp);
        c6 = longint'(cal.coeff_temp_sens);

        dt = d2 - c5 * 256;
        t1 = bpcf_pkg::TEMP_REF + ((dt * c6) >>> bpcf_pkg::T1_SHIFT);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        if (t1 < bpcf_pkg::TEMP_REF) begin
            x = (t1 - bpcf_pkg::TEMP_REF) * (t1 - bpcf_pkg::TEMP_REF);
            t2 = (dt * dt) >>> bpcf_pkg::T2_SHIFT;
            off2 = (5 * x) / 2;
            sens2 = (5 * x) / 4;
            if (t1 < bpcf_pkg::TEMP_LOW) begin
                y = (t1 - bpcf_pkg::TEMP_LOW) * (t1 - bpcf_pkg::TEMP_LOW);
                off2 = off2 + 7 * y;
                sens2 = sens2 + (11 * y) / 2;
            end
        end
        temp = t1 - t2;

        off = c2 * 65536 + ((c4 * dt) >>> bpcf_pkg::OFF_TC_SHIFT) - off2;
        sens = c1 * 32768 + ((c3 * dt) >>> bpcf_pkg::SENS_TC_SHIFT) - sens2;
        p = ((((d1 * sens) >>> bpcf_pkg::P_SHIFT1) - off) >>> bpcf_pkg::P_SHIFT2) * 10;
        p = clamp(p, longint'(bpcf_pkg::P_MIN), longint'(bpcf_pkg::P_MAX));

        sum = clamp(avg_sum - avg_value + p, longint'(bpcf_pkg::SUM_MIN),
                    longint'(bpcf_pkg::SUM_MAX));
        k = int'(cal.filter_shift);
        if (k < int'(bpcf_pkg::FILTER_SHIFT_MIN)) k = int'(bpcf_pkg::FILTER_SHIFT_MIN);
        if (k > int'(bpcf_pkg::FILTER_SHIFT_MAX)) k = int'(bpcf_pkg::FILTER_SHIFT_MAX);
        filt = (sum + (64'sd1 <<< (k - 1))) >>> k;
        filt = clamp(filt, longint'(bpcf_pkg::P_MIN), longint'(bpcf_pkg::P_MAX));
        avg_sum = sum;
        avg_value = filt;

        r.temperature = temp[18:0];
        r.pressure_comp = p[31:0];
        r.pressure_avg = filt[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        bpcf_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected transaction", longint'(o_out_data.pressure_comp), 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (o_out_data.temperature !== want.temperature)
                        report_mismatch("temperature", longint'(o_out_data.temperature),
                                        longint'(want.temperature));
                    if (o_out_data.pressure_comp !== want.pressure_comp)
                        report_mismatch("pressure_comp", longint'(o_out_data.pressure_comp),
                                        longint'(want.pressure_comp));
                    if (o_out_data.pressure_avg !== want.pressure_avg)
                        report_mismatch("pressure_avg", longint'(o_out_data.pressure_avg),
                                        longint'(want.pressure_avg));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input bpcf_pkg::t_in_item item);
        int gap = 0;
        while ($urandom_range(99) < send_gap_pct) gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        expected_readings.push_back(predict_reading(item));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] word);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            bpcf_pkg::REG_COEFF_SENS:          cal.coeff_sens = word[15:0];
            bpcf_pkg::REG_COEFF_OFFSET:        cal.coeff_offset = word[15:0];
            bpcf_pkg::REG_COEFF_SENS_TEMPCO:   cal.coeff_sens_tempco = word[15:0];
            bpcf_pkg::REG_COEFF_OFFSET_TEMPCO: cal.coeff_offset_tempco = word[15:0];
            bpcf_pkg::REG_COEFF_REF_TEMP:      cal.coeff_ref_temp = word[15:0];
            bpcf_pkg::REG_COEFF_TEMP_SENS:     cal.coeff_temp_sens = word[15:0];
            bpcf_pkg::REG_FILTER_SHIFT:        cal.filter_shift = word[4:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // unused upper bits carry noise; the block must ignore them
    task automatic write_calibration(input bpcf_pkg::t_cfg c);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(bpcf_pkg::REG_COEFF_SENS, {noise[31:16], c.coeff_sens});
        noise = $urandom;
        write_reg(bpcf_pkg::REG_COEFF_OFFSET, {noise[31:16], c.coeff_offset});
        noise = $urandom;
        write_reg(bpcf_pkg::REG_COEFF_SENS_TEMPCO, {noise[31:16], c.coeff_sens_tempco});
        noise = $urandom;
        write_reg(bpcf_pkg::REG_COEFF_OFFSET_TEMPCO, {noise[31:16], c.coeff_offset_tempco});
        noise = $urandom;
        write_reg(bpcf_pkg::REG_COEFF_REF_TEMP, {noise[31:16], c.coeff_ref_temp});
        noise = $urandom;
        write_reg(bpcf_pkg::REG_COEFF_TEMP_SENS, {noise[31:16], c.coeff_temp_sens});
        noise = $urandom;
        write_reg(bpcf_pkg::REG_FILTER_SHIFT, {noise[31:5], c.filter_shift});
    endtask

    function automatic bpcf_pkg::t_cfg nominal_calibration();
        bpcf_pkg::t_cfg c;
        c.coeff_sens = 16'd40127;
        c.coeff_offset = 16'd36924;
        c.coeff_sens_tempco = 16'd23317;
        c.coeff_offset_tempco = 16'd23282;
        c.coeff_ref_temp = 16'd33464;
        c.coeff_temp_sens = 16'd28312;
        c.filter_shift = bpcf_pkg::FILTER_SHIFT_RESET;
        return c;
    endfunction

    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] v);
        return 16'(int'(v) + int'($urandom_range(2000)) - 1000);
    endfunction

    function automatic bpcf_pkg::t_cfg rand_calibration(input bit near_nominal);
        bpcf_pkg::t_cfg c;
        c = nominal_calibration();
        if (near_nominal) begin
            c.coeff_sens = jitter(c.coeff_sens);
            c.coeff_offset = jitter(c.coeff_offset);
            c.coeff_sens_tempco = jitter(c.coeff_sens_tempco);
            c.coeff_offset_tempco = jitter(c.coeff_offset_tempco);
            c.coeff_ref_temp = jitter(c.coeff_ref_temp);
            c.coeff_temp_sens = jitter(c.coeff_temp_sens);
        end else begin
            c.coeff_sens = rand_coeff();
            c.coeff_offset = rand_coeff();
            c.coeff_sens_tempco = rand_coeff();
            c.coeff_offset_tempco = rand_coeff();
            c.coeff_ref_temp = rand_coeff();
            c.coeff_temp_sens = rand_coeff();
        end
        if ($urandom_range(3) == 0)
            c.filter_shift = 5'($urandom);
        else
            c.filter_shift = 5'($urandom_range(16, 1));
        return c;
    endfunction

    // mix of full-range words, readings near the reference temperature and extremes
    function automatic bpcf_pkg::t_in_item rand_reading();
        bpcf_pkg::t_in_item item;
        longint centre;
        case ($urandom_range(3))
            0, 1: begin
                item.raw_pressure = 24'($urandom);
                item.raw_temp = 24'($urandom);
            end
            2: begin
                centre = longint'(cal.coeff_ref_temp) * 256;
                item.raw_pressure = 24'($urandom_range(10000000, 6000000));
                item.raw_temp = 24'(clamp(centre + longint'($urandom_range(4000000)) - 2000000,
                                          0, 24'hFFFFFF));
            end
            default: begin
                item.raw_pressure = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                item.raw_temp = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            end
        endcase
        return item;
    endfunction

    function automatic bpcf_pkg::t_in_item reading(input logic [23:0] d1,
                                                   input logic [23:0] d2);
        bpcf_pkg::t_in_item item;
        item.raw_pressure = d1;
        item.raw_temp = d2;
        return item;
    endfunction

    task automatic test_reset_values();
        send_item(reading(24'h000000, 24'h000000));
        send_item(reading(24'hFFFFFF, 24'hFFFFFF));
        send_item(reading(24'($urandom), 24'($urandom)));
        wait_idle();
    endtask

    task automatic test_nominal_readings();
        write_calibration(nominal_calibration());
        send_item(reading(24'd9085466, 24'd8569150));
        send_item(reading(24'd9085466, 24'd8000000));
        send_item(reading(24'd9085466, 24'd6000000));
        send_item(reading(24'd9085466, 24'd0));
        send_item(reading(24'd9085466, 24'hFFFFFF));
        send_item(reading(24'd0, 24'd8569150));
        send_item(reading(24'hFFFFFF, 24'd0));
        send_item(reading(24'hFFFFFF, 24'hFFFFFF));
        wait_idle();
    endtask

    // reference at 2^22 and a 1/1024 slope put the edges of the cold and
    // very cold ranges on exact raw temperature words
    task automatic test_temperature_boundaries();
        bpcf_pkg::t_cfg c;
        c = nominal_calibration();
        c.coeff_ref_temp = 16'd16384;
        c.coeff_temp_sens = 16'd8192;
        write_calibration(c);
        send_item(reading(24'd9085466, 24'd4194304));
        send_item(reading(24'd9085466, 24'd4194303));
        send_item(reading(24'd9085466, 24'd610304));
        send_item(reading(24'd9085466, 24'd610303));
        send_item(reading(24'hFFFFFF, 24'd0));
        wait_idle();
    endtask

    task automatic test_reserved_register();
        write_reg(REG_RESERVED, $urandom);
        repeat (3) send_item(rand_reading());
        wait_idle();
    endtask

    task automatic test_shift_range();
        logic [4:0] shifts[6];
        logic [31:0] noise;
        shifts = '{5'd0, bpcf_pkg::FILTER_SHIFT_MIN, bpcf_pkg::FILTER_SHIFT_MAX, 5'd17, 5'd31,
                   bpcf_pkg::FILTER_SHIFT_RESET};
        foreach (shifts[i]) begin
            noise = $urandom;
            write_reg(bpcf_pkg::REG_FILTER_SHIFT, {noise[31:5], shifts[i]});
            repeat (25) send_item(rand_reading());
            wait_idle();
        end
    endtask

    task automatic test_random_readings();
        for (int phase = 0; phase < 9; phase++) begin
            write_calibration(rand_calibration(phase % 2 == 0));
            send_gap_pct = (phase == 4) ? 0 : IDLE_PCT;
            stall_pct = (phase == 4) ? 0 : IDLE_PCT;
            repeat (200) send_item(rand_reading());
            wait_idle();
        end
        send_gap_pct = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    initial begin
        cal = '0;
        cal.filter_shift = bpcf_pkg::FILTER_SHIFT_RESET;
        avg_sum = 0;
        avg_value = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_nominal_readings();
        test_temperature_boundaries();
        test_reserved_register();
        test_shift_range();
        test_random_readings();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
